// ===== hw/rtl/lcg_pkg.sv =====
// Shared constants and types of the modular linear congruential generator.
package lcg_pkg;

    localparam int STATE_BITS_DEFAULT    = 63;
    localparam int FRACTION_BITS_DEFAULT = 32;

    // Fixed Mersenne modulus used for the integer output.
    localparam int INT_BITS               = 31;
    localparam logic [INT_BITS-1:0] INT_MODULUS = 31'h7FFF_FFFF;
    // Sum of three 31-bit chunks of the state.
    localparam int FOLD_BITS              = INT_BITS + 2;

    // Reset values of the configuration registers.
    localparam longint unsigned MULTIPLIER_RESET = 64'd16807;
    localparam longint unsigned INCREMENT_RESET  = 64'd0;
    localparam longint unsigned MODULUS_RESET    = 64'd2147483647;
    localparam longint unsigned STATE_RESET      = 64'd1;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MULTIPLIER = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INCREMENT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS    = 2'd2;

    // Item kinds carried in the input tuser.
    localparam logic ACTION_DRAW = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_SEED_RANGE = 2'd1,
        STATUS_CONFIG     = 2'd2
    } status_t;

endpackage

// ===== hw/rtl/lcg_modular_generator.sv =====
// Top level of the modular linear congruential generator with stream ports.
//
// Usage: write multiplier, increment and modulus through the cfg_* port while
// the block is idle, then send items on the s_axis channel. tuser selects the
// kind (draw or load), tdata carries the seed of a load. Every item returns one
// transaction on m_axis: new state, state mod 2^31-1, the 0.FRACTION_BITS
// fraction state/modulus, and a status code in tuser.
//
// Steps: a draw first reduces the state when it is not below the modulus,
// forms the product by double-and-add, then adds the increment; loads and
// refused items go straight to the fraction, whose division is skipped when
// the fraction saturates; the Mersenne fold of the state into the integer
// output comes last. The reduction, the product and the division all run
// through the one compare-and-subtract unit: one step of the state reduction,
// of the double-and-add product or of the fraction division per cycle.
// The input is ready only while the sequencer is idle; one item is in flight.
//
// Reset loads multiplier 16807, increment 0, modulus 2^31-1 and state 1, and
// empties the output register. When the receiver stalls, the finished result
// holds in the output register; the next item may still be accepted and
// worked on, and its result waits in the sequencer until the register frees.
module lcg_modular_generator
    import lcg_pkg::*;
#(
    parameter int STATE_BITS    = STATE_BITS_DEFAULT,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
    localparam int IN_TDATA_W   = ((STATE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS     = STATE_BITS + INT_BITS + FRACTION_BITS,
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [STATE_BITS-1:0]     cfg_data,

    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_W-1:0]     s_axis_tdata,   // seed_value
    input  logic [0:0]                s_axis_tuser,   // action

    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_W-1:0]    m_axis_tdata,   // current_state, int_value, fraction
    output logic [1:0]                m_axis_tuser    // status
);

    // Configuration registers.
    logic [STATE_BITS-1:0]    multiplier_reg;
    logic [STATE_BITS-1:0]    increment_reg;
    logic [STATE_BITS-1:0]    modulus_reg;

    // Output register.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [STATE_BITS-1:0]    out_state_reg;
    logic [INT_BITS-1:0]      out_int_reg;
    logic [FRACTION_BITS-1:0] out_frac_reg;
    status_t                  out_status_reg;

    logic                     core_ready;
    logic                     core_start;
    logic                     res_valid;
    logic                     res_ready;
    logic                     res_take;
    logic [STATE_BITS-1:0]    res_state;
    logic [INT_BITS-1:0]      res_int;
    logic [FRACTION_BITS-1:0] res_frac;
    status_t                  res_status;

    // Writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiplier_reg <= STATE_BITS'(MULTIPLIER_RESET);
            increment_reg  <= STATE_BITS'(INCREMENT_RESET);
            modulus_reg    <= STATE_BITS'(MODULUS_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MULTIPLIER: multiplier_reg <= cfg_data;
                REG_INCREMENT:  increment_reg  <= cfg_data;
                REG_MODULUS:    modulus_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign s_axis_tready = core_ready;
    assign core_start    = s_axis_tvalid & core_ready;

    lcg_core #(
        .STATE_BITS    (STATE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (core_start),
        .action        (s_axis_tuser[0]),
        .seed          (s_axis_tdata[STATE_BITS-1:0]),
        .multiplier    (multiplier_reg),
        .increment     (increment_reg),
        .modulus       (modulus_reg),
        .ready         (core_ready),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .current_state (res_state),
        .int_value     (res_int),
        .fraction      (res_frac),
        .status        (res_status)
    );

    // Take a finished result whenever the output register is empty or draining.
    assign res_ready = ~out_valid_reg | m_axis_tready;
    assign res_take  = res_valid & res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Payload holds while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_state_reg  <= res_state;
            out_int_reg    <= res_int;
            out_frac_reg   <= res_frac;
            out_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_frac_reg, out_int_reg, out_state_reg});
    assign m_axis_tuser  = out_status_reg;

endmodule

// ===== hw/rtl/lcg_mod_unit.sv =====
// Shared compare-and-subtract unit: reduce an operand below twice the modulus.
module lcg_mod_unit
    import lcg_pkg::*;
#(
    parameter int STATE_BITS = STATE_BITS_DEFAULT
)
(
    input  logic [STATE_BITS:0]   operand,
    input  logic [STATE_BITS-1:0] modulus,
    output logic [STATE_BITS-1:0] remainder,
    output logic                  ge
);

    logic [STATE_BITS+1:0] diff;

    assign diff      = {1'b0, operand} - {2'b00, modulus};
    assign ge        = ~diff[STATE_BITS+1];
    // Subtract once when the operand reaches the modulus, else pass it through.
    assign remainder = ge ? diff[STATE_BITS-1:0] : operand[STATE_BITS-1:0];

endmodule

// ===== hw/rtl/lcg_core.sv =====
// Sequencer and datapath registers of the generator around the shared unit.
module lcg_core
    import lcg_pkg::*;
#(
    parameter int STATE_BITS    = STATE_BITS_DEFAULT,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     action,
    input  logic [STATE_BITS-1:0]    seed,
    input  logic [STATE_BITS-1:0]    multiplier,
    input  logic [STATE_BITS-1:0]    increment,
    input  logic [STATE_BITS-1:0]    modulus,
    output logic                     ready,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [STATE_BITS-1:0]    current_state,
    output logic [INT_BITS-1:0]      int_value,
    output logic [FRACTION_BITS-1:0] fraction,
    output status_t                  status
);

    localparam int MAX_STEPS = (STATE_BITS > FRACTION_BITS) ? STATE_BITS : FRACTION_BITS;
    localparam int CNT_W     = $clog2(MAX_STEPS);
    localparam int SIDX_W    = $clog2(STATE_BITS);
    localparam int WIDE_BITS = 3 * INT_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCHK,
        ST_RED,
        ST_MUL_DBL,
        ST_MUL_ADD,
        ST_ADD_C,
        ST_FCHK,
        ST_FRAC,
        ST_FOLD,
        ST_MERS,
        ST_DONE
    } seq_state_t;

    seq_state_t                 seq_reg;
    logic [STATE_BITS-1:0]      gen_state_reg;
    logic [STATE_BITS-1:0]      acc_reg;
    logic [STATE_BITS-1:0]      sred_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [FOLD_BITS-1:0]       fold_reg;
    logic [INT_BITS-1:0]        int_reg;
    logic [FRACTION_BITS-1:0]   frac_reg;
    status_t                    status_reg;

    logic [STATE_BITS:0]        unit_operand;
    logic [STATE_BITS-1:0]      unit_remainder;
    logic                       unit_ge;
    logic                       cfg_ok;
    logic                       seed_ok;
    logic [WIDE_BITS-1:0]       gen_wide;
    logic [FOLD_BITS-1:0]       fold_sum;
    logic [INT_BITS:0]          mers_sum;

    assign cfg_ok  = (multiplier != '0) && (multiplier < modulus) && (increment < modulus);
    assign seed_ok = (seed != '0) && (seed < modulus);

    // Mersenne fold of the state into three 31-bit chunks.
    assign gen_wide = WIDE_BITS'(gen_state_reg);
    assign fold_sum = FOLD_BITS'(gen_wide[INT_BITS-1:0])
                    + FOLD_BITS'(gen_wide[2*INT_BITS-1:INT_BITS])
                    + FOLD_BITS'(gen_wide[3*INT_BITS-1:2*INT_BITS]);
    assign mers_sum = (INT_BITS+1)'(fold_reg[INT_BITS-1:0])
                    + (INT_BITS+1)'(fold_reg[FOLD_BITS-1:INT_BITS]);

    // Select what the shared unit works on in each step.
    always_comb
    begin
        case (seq_reg)
            ST_SCHK, ST_FCHK: unit_operand = {1'b0, gen_state_reg};
            ST_RED:           unit_operand = {acc_reg, gen_state_reg[cnt_reg[SIDX_W-1:0]]};
            ST_MUL_DBL,
            ST_FRAC:          unit_operand = {acc_reg, 1'b0};
            ST_MUL_ADD:       unit_operand = {1'b0, acc_reg} + {1'b0, sred_reg};
            ST_ADD_C:         unit_operand = {1'b0, acc_reg} + {1'b0, increment};
            default:          unit_operand = '0;
        endcase
    end

    lcg_mod_unit #(
        .STATE_BITS (STATE_BITS)
    ) u_mod_unit (
        .operand   (unit_operand),
        .modulus   (modulus),
        .remainder (unit_remainder),
        .ge        (unit_ge)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= ST_IDLE;
            gen_state_reg <= STATE_BITS'(STATE_RESET);
            acc_reg       <= '0;
            sred_reg      <= '0;
            cnt_reg       <= '0;
            fold_reg      <= '0;
            int_reg       <= '0;
            frac_reg      <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            case (seq_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (!cfg_ok)
                        begin
                            status_reg <= STATUS_CONFIG;
                            seq_reg    <= ST_FCHK;
                        end
                        else if (action == ACTION_LOAD)
                        begin
                            if (seed_ok)
                            begin
                                gen_state_reg <= seed;
                                status_reg    <= STATUS_OK;
                            end
                            else
                            begin
                                status_reg <= STATUS_SEED_RANGE;
                            end
                            seq_reg <= ST_FCHK;
                        end
                        else
                        begin
                            status_reg <= STATUS_OK;
                            seq_reg    <= ST_SCHK;
                        end
                    end
                end
                ST_SCHK:
                begin
                    // Reduce the state first only when it is not below the modulus.
                    acc_reg <= '0;
                    cnt_reg <= CNT_W'(STATE_BITS - 1);
                    if (unit_ge)
                    begin
                        seq_reg <= ST_RED;
                    end
                    else
                    begin
                        sred_reg <= gen_state_reg;
                        seq_reg  <= ST_MUL_DBL;
                    end
                end
                ST_RED:
                begin
                    if (cnt_reg == '0)
                    begin
                        sred_reg <= unit_remainder;
                        acc_reg  <= '0;
                        cnt_reg  <= CNT_W'(STATE_BITS - 1);
                        seq_reg  <= ST_MUL_DBL;
                    end
                    else
                    begin
                        acc_reg <= unit_remainder;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_MUL_DBL:
                begin
                    acc_reg <= unit_remainder;
                    if (multiplier[cnt_reg[SIDX_W-1:0]])
                        seq_reg <= ST_MUL_ADD;
                    else if (cnt_reg == '0)
                        seq_reg <= ST_ADD_C;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                ST_MUL_ADD:
                begin
                    acc_reg <= unit_remainder;
                    if (cnt_reg == '0)
                    begin
                        seq_reg <= ST_ADD_C;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        seq_reg <= ST_MUL_DBL;
                    end
                end
                ST_ADD_C:
                begin
                    gen_state_reg <= unit_remainder;
                    seq_reg       <= ST_FCHK;
                end
                ST_FCHK:
                begin
                    acc_reg <= gen_state_reg;
                    cnt_reg <= CNT_W'(FRACTION_BITS - 1);
                    if (modulus == '0)
                    begin
                        frac_reg <= '0;
                        seq_reg  <= ST_FOLD;
                    end
                    else if (unit_ge)
                    begin
                        frac_reg <= '1;
                        seq_reg  <= ST_FOLD;
                    end
                    else
                    begin
                        frac_reg <= '0;
                        seq_reg  <= ST_FRAC;
                    end
                end
                ST_FRAC:
                begin
                    acc_reg  <= unit_remainder;
                    frac_reg <= {frac_reg[FRACTION_BITS-2:0], unit_ge};
                    if (cnt_reg == '0)
                        seq_reg <= ST_FOLD;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                ST_FOLD:
                begin
                    fold_reg <= fold_sum;
                    seq_reg  <= ST_MERS;
                end
                ST_MERS:
                begin
                    if (mers_sum >= (INT_BITS+1)'(INT_MODULUS))
                        int_reg <= INT_BITS'(mers_sum - (INT_BITS+1)'(INT_MODULUS));
                    else
                        int_reg <= mers_sum[INT_BITS-1:0];
                    seq_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (res_ready)
                        seq_reg <= ST_IDLE;
                end
                default:
                begin
                    seq_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign ready         = (seq_reg == ST_IDLE);
    assign res_valid     = (seq_reg == ST_DONE);
    assign current_state = gen_state_reg;
    assign int_value     = int_reg;
    assign fraction      = frac_reg;
    assign status        = status_reg;

endmodule

// ===== sim/lcg_checker.sv =====
// Result checker for the modular LCG: tracks configuration, predicts and compares results.
module lcg_checker
    import lcg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [62:0]               cfg_data,

    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [63:0]               s_axis_tdata,   // seed_value
    input  logic [0:0]                s_axis_tuser,   // action

    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [127:0]              m_axis_tdata,   // current_state, int_value, fraction
    input  logic [1:0]                m_axis_tuser,   // status

    output int                        error_count,
    output int                        in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB       = STATE_BITS_DEFAULT;
    localparam int FB       = FRACTION_BITS_DEFAULT;
    localparam int INT_LSB  = SB;
    localparam int FRAC_LSB = SB + INT_BITS;
    localparam int PRINT_CAP = 60;

    typedef struct {
        logic [SB-1:0]       cur_state;
        logic [INT_BITS-1:0] int_value;
        logic [FB-1:0]       fraction;
        status_t             status;
    } lcg_result_t;

    logic [SB-1:0] mult_q;
    logic [SB-1:0] incr_q;
    logic [SB-1:0] modulus_q;
    logic [SB-1:0] gen_state;

    lcg_result_t outputs_due[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < PRINT_CAP)
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Advance the generator copy by one item and form the result it produces.
    function automatic lcg_result_t advance_generator(input logic action,
                                                      input logic [SB-1:0] seed);
        lcg_result_t res;
        logic [127:0] wide;
        logic [SB-1:0] rem;
        res.status = STATUS_OK;
        if (mult_q == '0 || mult_q >= modulus_q || incr_q >= modulus_q)
            res.status = STATUS_CONFIG;
        else if (action == ACTION_LOAD)
        begin
            if (seed != '0 && seed < modulus_q)
                gen_state = seed;
            else
                res.status = STATUS_SEED_RANGE;
        end
        else
        begin
            // exact product, then fold in the increment
            wide = 128'(mult_q) * 128'(gen_state % modulus_q);
            wide = (wide % 128'(modulus_q) + 128'(incr_q)) % 128'(modulus_q);
            gen_state = wide[SB-1:0];
        end
        res.cur_state = gen_state;
        rem = gen_state % SB'(INT_MODULUS);
        res.int_value = rem[INT_BITS-1:0];
        if (modulus_q == '0)
            res.fraction = '0;
        else if (gen_state >= modulus_q)
            res.fraction = '1;
        else
        begin
            wide = (128'(gen_state) << FB) / 128'(modulus_q);
            res.fraction = wide[FB-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lcg_result_t want;
        if (!rst_n)
        begin
            mult_q      = SB'(MULTIPLIER_RESET);
            incr_q      = SB'(INCREMENT_RESET);
            modulus_q   = SB'(MODULUS_RESET);
            gen_state   = SB'(STATE_RESET);
            outputs_due.delete();
            error_count = 0;
            in_flight   = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MULTIPLIER: mult_q    = cfg_data;
                    REG_INCREMENT:  incr_q    = cfg_data;
                    REG_MODULUS:    modulus_q = cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (outputs_due.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
                else
                begin
                    want = outputs_due.pop_front();
                    if (m_axis_tdata[SB-1:0] !== want.cur_state)
                        report_mismatch("current_state", m_axis_tdata[SB-1:0], want.cur_state);
                    if (m_axis_tdata[INT_LSB +: INT_BITS] !== want.int_value)
                        report_mismatch("int_value", m_axis_tdata[INT_LSB +: INT_BITS],
                                        want.int_value);
                    if (m_axis_tdata[FRAC_LSB +: FB] !== want.fraction)
                        report_mismatch("fraction", m_axis_tdata[FRAC_LSB +: FB], want.fraction);
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                outputs_due.push_back(advance_generator(s_axis_tuser[0], s_axis_tdata[SB-1:0]));
            in_flight = outputs_due.size();
        end
    end

endmodule

// ===== sim/tb_lcg_modular_generator.sv =====
// Testbench top for the modular LCG: drives items and configuration, gives the verdict.
module tb_lcg_modular_generator
    import lcg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MAX_VALUE   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          ITEM_TARGET = 1750;
    // Watchdog bound: the slowest draw plus both sides' worst idling,
    // taken several times over.
    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam int          TAIL_CYCLES = 250;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [62:0]               cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [63:0]               s_axis_tdata;   // seed_value
    logic [0:0]                s_axis_tuser;   // action
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [127:0]              m_axis_tdata;   // current_state, int_value, fraction
    logic [1:0]                m_axis_tuser;   // status

    int  mismatches;
    int  in_flight;
    int  cycle_count;
    int  items_sent;
    bit  quiet;          // no idling on either side while set

    lcg_modular_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lcg_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (mismatches),
        .in_flight     (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [62:0] rand63();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[62:0];
    endfunction

    // Present one item after a random gap and hold it until the transaction.
    // Valid stays high on return; the caller either replaces the item or
    // drops valid in this same step.
    task automatic send_item(input logic action, input logic [62:0] seed);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = action;
        s_axis_tdata  = {1'b0, seed};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (in_flight != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [62:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Reprogram all three registers, only with the block idle.
    task automatic set_config(input logic [62:0] a, input logic [62:0] c,
                              input logic [62:0] m);
        wait_drained();
        write_reg(REG_MULTIPLIER, a);
        write_reg(REG_INCREMENT, c);
        write_reg(REG_MODULUS, m);
    endtask

    // One random configuration followed by a run of mostly draws.
    task automatic random_phase();
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] c;
        logic [63:0] seed;
        int          len;
        int          count;
        int          kind;
        bit          cfg_bad;
        kind    = $urandom_range(0, 19);
        cfg_bad = 1'b0;
        quiet   = ($urandom_range(0, 3) == 0);
        count   = $urandom_range(60, 200);
        if (kind == 0)
        begin
            // the classic minimal-standard setting
            a = MULTIPLIER_RESET;
            c = INCREMENT_RESET;
            m = MODULUS_RESET;
        end
        else
        begin
            // modulus of random magnitude, top bit of its length forced
            len = $urandom_range(2, 63);
            m = ({1'b0, rand63()} >> (63 - len)) | (64'd1 << (len - 1));
            case ($urandom_range(0, 5))
                0:       a = 64'd1;
                1:       a = m - 1;
                default: a = 64'd1 + {1'b0, rand63()} % (m - 1);
            endcase
            case ($urandom_range(0, 5))
                0:       c = 64'd0;
                1:       c = m - 1;
                default: c = {1'b0, rand63()} % m;
            endcase
            if (kind == 1)
            begin
                // break one of the three rules; keep such phases short
                cfg_bad = 1'b1;
                count   = $urandom_range(6, 12);
                case ($urandom_range(0, 2))
                    0:       a = 64'd0;
                    1:       a = m + {1'b0, rand63()} % (MAX_VALUE - m + 1);
                    default: c = m + {1'b0, rand63()} % (MAX_VALUE - m + 1);
                endcase
            end
        end
        set_config(a[62:0], c[62:0], m[62:0]);
        repeat (count)
        begin
            if ($urandom_range(0, 15) < 12)
                send_item(ACTION_DRAW, rand63());
            else
            begin
                case ($urandom_range(0, 7))
                    0:       seed = 64'd0;
                    1:       seed = m;
                    2:       seed = {1'b0, rand63()};
                    3:       seed = m - 1;
                    default: seed = 64'd1 + {1'b0, rand63()} % (m - 1);
                endcase
                send_item(ACTION_LOAD, seed[62:0]);
            end
            // now and then let the pipeline run dry before the next item
            if (!cfg_bad && $urandom_range(0, 63) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = REG_MULTIPLIER;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACTION_DRAW;
        cycle_count   = 0;
        items_sent    = 0;
        quiet         = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset configuration: first draw from state one, seed bounds.
        send_item(ACTION_DRAW, 63'd0);
        send_item(ACTION_LOAD, 63'd1);
        send_item(ACTION_DRAW, '1);
        send_item(ACTION_LOAD, 63'd2147483646);
        send_item(ACTION_DRAW, 63'd0);
        send_item(ACTION_LOAD, 63'd0);
        send_item(ACTION_LOAD, 63'd2147483647);
        send_item(ACTION_LOAD, '1);

        // Largest modulus with multiplier and increment at their ceiling;
        // the last load leaves the state at modulus minus one.
        set_config(MAX_VALUE[62:0] - 63'd1, MAX_VALUE[62:0] - 63'd1, MAX_VALUE[62:0]);
        send_item(ACTION_LOAD, 63'd1);
        send_item(ACTION_DRAW, 63'd0);
        send_item(ACTION_LOAD, '1);
        send_item(ACTION_DRAW, '1);
        send_item(ACTION_LOAD, MAX_VALUE[62:0] - 63'd1);

        // Shrink the modulus under the large state: a refused load shows the
        // saturated fraction, then a draw has to reduce the state first.
        set_config(63'd7, 63'd999, 63'd1000);
        send_item(ACTION_LOAD, 63'd0);
        send_item(ACTION_DRAW, 63'd0);

        // Each broken configuration rule refuses draws and loads alike.
        set_config(63'd0, 63'd3, 63'd1000);
        send_item(ACTION_DRAW, 63'd0);
        send_item(ACTION_LOAD, 63'd5);
        set_config(63'd1000, 63'd3, 63'd1000);
        send_item(ACTION_DRAW, 63'd0);
        set_config(63'd7, 63'd1000, 63'd1000);
        send_item(ACTION_LOAD, 63'd5);

        // Smallest modulus.
        set_config(63'd1, 63'd1, 63'd2);
        send_item(ACTION_LOAD, 63'd1);
        send_item(ACTION_DRAW, 63'd0);
        send_item(ACTION_DRAW, 63'd0);
        send_item(ACTION_LOAD, 63'd2);

        while (items_sent < ITEM_TARGET)
            random_phase();

        quiet = 1'b0;
        wait_drained();
        // let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && in_flight == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: hold ready low for a random gap before each transaction.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

endmodule
